>>> hdl/deque_with_prefix_copy_core_defines.svh
// Assertion macros shared by the deque core RTL.
`ifndef DEQUE_WITH_PREFIX_COPY_CORE_DEFINES_SVH
`define DEQUE_WITH_PREFIX_COPY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define DWPC_CHECK(lbl, ena, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ena) |-> (prop)) \
        else $error("dwpc check failed");
// next-cycle implication, disabled in reset
`define DWPC_CHECK_NEXT(lbl, ena, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ena) |=> (prop)) \
        else $error("dwpc next-cycle check failed");
`else
`define DWPC_CHECK(lbl, ena, prop)
`define DWPC_CHECK_NEXT(lbl, ena, prop)
`endif

`endif

>>> hdl/dwpc_pkg.sv
// Shared constants, types and ring arithmetic for the deque core.
`default_nettype none

package dwpc_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // port widths
    localparam int ACT_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT  = 2'd0,
        ACT_PUSH_BACK   = 2'd1,
        ACT_POP_FRONT   = 2'd2,
        ACT_COPY_PREFIX = 2'd3
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_FEW   = 2'd3
    } st_t;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        act_t               op;
        word_t              word;
        logic [COUNT_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        st_t   status;
        word_t rvalue;
        cnt_t  fill;
    } res_t;

    // (base + off) mod DEPTH, base < DEPTH, off <= DEPTH
    function automatic addr_t ring_add(input addr_t base, input cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
            sum = sum - (CNT_W+1)'(DEPTH);
        return ADDR_W'(sum);
    endfunction

    // (base - off) mod DEPTH, base < DEPTH, off <= DEPTH
    function automatic addr_t ring_sub(input addr_t base, input cnt_t off);
        logic [CNT_W:0] b;
        logic [CNT_W:0] o;
        logic [CNT_W:0] r;
        b = (CNT_W+1)'(base);
        o = (CNT_W+1)'(off);
        if (b >= o)
            r = b - o;
        else
            r = b + (CNT_W+1)'(DEPTH) - o;
        return ADDR_W'(r);
    endfunction

endpackage

`default_nettype wire

>>> hdl/dwpc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dwpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/dwpc_front.sv
// Front end: takes input transfers, decodes them and holds them in a short command queue.
`default_nettype none

module dwpc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [dwpc_pkg::ACT_W-1:0]       action,
    input  wire logic [dwpc_pkg::VALUE_W-1:0]     value,
    input  wire logic [dwpc_pkg::COUNT_W-1:0]     count,
    output logic                                  q_valid,
    input  wire logic                             q_ready,
    output dwpc_pkg::cmd_t                        q_cmd
);

    dwpc_pkg::cmd_t                    cmd_in;
    dwpc_pkg::cmd_t                    ent_reg [dwpc_pkg::QDEPTH];
    logic [63:0]                       value_ext;
    logic [dwpc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dwpc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dwpc_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              push;
    logic                              pop;

    assign value_ext = 64'(value);

    always_comb
    begin
        cmd_in.op   = dwpc_pkg::act_t'(action);
        cmd_in.word = value_ext[dwpc_pkg::WORD_WIDTH-1:0];
        cmd_in.k    = count;
    end

    assign in_ready = (cnt_reg != dwpc_pkg::QCNT_W'(dwpc_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == dwpc_pkg::QPTR_W'(dwpc_pkg::QDEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + dwpc_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            if (rd_ptr_reg == dwpc_pkg::QPTR_W'(dwpc_pkg::QDEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + dwpc_pkg::QPTR_W'(1);
        end
        if (push && !pop)
            cnt_next = cnt_reg + dwpc_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - dwpc_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dwpc_back.sv
// Back end: executes queued commands on the ring store and registers the result.
`default_nettype none

module dwpc_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_valid,
    output logic                                  q_ready,
    input  wire dwpc_pkg::cmd_t                   q_cmd,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [dwpc_pkg::STATUS_W-1:0]         status,
    output logic [dwpc_pkg::VALUE_W-1:0]          result_value,
    output logic [dwpc_pkg::FILL_W-1:0]           fill,
    output logic                                  is_empty
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_COPY = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    dwpc_pkg::addr_t   front_reg, front_next;
    dwpc_pkg::cnt_t    count_reg, count_next;
    dwpc_pkg::addr_t   src_reg, src_next;
    dwpc_pkg::addr_t   dst_reg, dst_next;
    dwpc_pkg::addr_t   new_front_reg, new_front_next;
    dwpc_pkg::cnt_t    left_reg, left_next;
    dwpc_pkg::cnt_t    k_reg, k_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    dwpc_pkg::res_t    res_reg, res_next;

    logic              we;
    dwpc_pkg::addr_t   waddr;
    dwpc_pkg::word_t   wdata;
    dwpc_pkg::addr_t   raddr;
    dwpc_pkg::word_t   rdata;

    logic              out_free;
    logic              res_load;
    dwpc_pkg::st_t     st_sel;
    dwpc_pkg::word_t   rv_sel;
    logic [31:0]       k_wide;
    logic [31:0]       cnt_wide;
    dwpc_pkg::cnt_t    k_cnt;
    logic [63:0]       rv_ext;
    logic [31:0]       fill_ext;

    dwpc_ram #(
        .WIDTH (dwpc_pkg::WORD_WIDTH),
        .DEPTH (dwpc_pkg::DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign k_wide   = 32'(q_cmd.k);
    assign cnt_wide = 32'(count_reg);
    assign k_cnt    = dwpc_pkg::CNT_W'(k_wide);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        new_front_next = new_front_reg;
        left_next      = left_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        we             = 1'b0;
        waddr          = front_reg;
        wdata          = q_cmd.word;
        raddr          = front_reg;
        q_ready        = 1'b0;
        res_load       = 1'b0;
        st_sel         = dwpc_pkg::ST_OK;
        rv_sel         = '0;

        case (state_reg)
            S_IDLE:
            begin
                // only start when the result register will be free at completion
                if (q_valid && out_free)
                begin
                    q_ready = 1'b1;
                    case (q_cmd.op)
                        dwpc_pkg::ACT_PUSH_FRONT:
                        begin
                            res_load = 1'b1;
                            if (count_reg >= dwpc_pkg::CNT_W'(dwpc_pkg::DEPTH))
                            begin
                                st_sel = dwpc_pkg::ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = dwpc_pkg::ring_sub(front_reg,
                                                                dwpc_pkg::CNT_W'(1));
                                front_next = waddr;
                                count_next = count_reg + dwpc_pkg::CNT_W'(1);
                            end
                        end
                        dwpc_pkg::ACT_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (count_reg >= dwpc_pkg::CNT_W'(dwpc_pkg::DEPTH))
                            begin
                                st_sel = dwpc_pkg::ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = dwpc_pkg::ring_add(front_reg, count_reg);
                                count_next = count_reg + dwpc_pkg::CNT_W'(1);
                            end
                        end
                        dwpc_pkg::ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                                st_sel   = dwpc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // read of the front word is issued here
                                state_next = S_POP;
                            end
                        end
                        dwpc_pkg::ACT_COPY_PREFIX:
                        begin
                            if (k_wide > cnt_wide)
                            begin
                                res_load = 1'b1;
                                st_sel   = dwpc_pkg::ST_FEW;
                            end
                            else if (cnt_wide + k_wide > 32'(dwpc_pkg::DEPTH))
                            begin
                                res_load = 1'b1;
                                st_sel   = dwpc_pkg::ST_FULL;
                            end
                            else if (k_wide == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                src_next       = front_reg;
                                dst_next       = dwpc_pkg::ring_sub(front_reg, k_cnt);
                                new_front_next = dst_next;
                                left_next      = k_cnt;
                                k_next         = k_cnt;
                                pend_next      = 1'b0;
                                state_next     = S_COPY;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_load   = 1'b1;
                rv_sel     = rdata;
                front_next = dwpc_pkg::ring_add(front_reg, dwpc_pkg::CNT_W'(1));
                count_next = count_reg - dwpc_pkg::CNT_W'(1);
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                // read word i while writing word i-1 below the old front
                raddr = src_reg;
                if (pend_reg)
                begin
                    we       = 1'b1;
                    waddr    = dst_reg;
                    wdata    = rdata;
                    dst_next = dwpc_pkg::ring_add(dst_reg, dwpc_pkg::CNT_W'(1));
                end
                if (left_reg != '0)
                begin
                    src_next  = dwpc_pkg::ring_add(src_reg, dwpc_pkg::CNT_W'(1));
                    left_next = left_reg - dwpc_pkg::CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && left_reg == '0)
                begin
                    res_load   = 1'b1;
                    front_next = new_front_reg;
                    count_next = count_reg + k_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.status = st_sel;
        res_next.rvalue = rv_sel;
        res_next.fill   = count_next;

        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            new_front_reg <= '0;
            left_reg      <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            new_front_reg <= new_front_next;
            left_reg      <= left_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign rv_ext       = 64'(res_reg.rvalue);
    assign fill_ext     = 32'(res_reg.fill);
    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign result_value = rv_ext[dwpc_pkg::VALUE_W-1:0];
    assign fill         = fill_ext[dwpc_pkg::FILL_W-1:0];
    assign is_empty     = (res_reg.fill == '0);

endmodule

`default_nettype wire

>>> hdl/deque_with_prefix_copy_core.sv
// A transfer is registered in the command queue, executed by the back end (a pop front via
// S_POP, a copy prefix via S_COPY, neither taking a new command meanwhile) and its result
// registered. One push per cycle while out_ready is high; copy prefix moves one word per cycle
// through the single read and single write port of the ring RAM. A two-entry command queue
// lets new transfers be taken while the back end is busy. Reset (rst_n, async, active low)
// empties the deque and the queue; RAM contents stay undefined, and no clearing pass is run.
`default_nettype none
`include "deque_with_prefix_copy_core_defines.svh"

module deque_with_prefix_copy_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [dwpc_pkg::ACT_W-1:0]       action,
    input  wire logic [dwpc_pkg::VALUE_W-1:0]     value,
    input  wire logic [dwpc_pkg::COUNT_W-1:0]     count,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [dwpc_pkg::STATUS_W-1:0]         status,
    output logic [dwpc_pkg::VALUE_W-1:0]          result_value,
    output logic [dwpc_pkg::FILL_W-1:0]           fill,
    output logic                                  is_empty
);

    logic            q_valid;
    logic            q_ready;
    dwpc_pkg::cmd_t  q_cmd;

    dwpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .value    (value),
        .count    (count),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    dwpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .fill         (fill),
        .is_empty     (is_empty)
    );

    // a failed action never returns a word
    `DWPC_CHECK(a_fail_no_word, out_valid && (status != dwpc_pkg::ST_OK), result_value == '0)
    // empty pop leaves the deque empty
    `DWPC_CHECK(a_empty_pop, out_valid && (status == dwpc_pkg::ST_EMPTY), is_empty && fill == '0)
    // fill stays within capacity
    `DWPC_CHECK(a_fill_cap, out_valid, 32'(fill) <= 32'(dwpc_pkg::DEPTH))
    // a queued command not taken by the back end stays queued
    `DWPC_CHECK_NEXT(a_queue_hold, q_valid && !q_ready, q_valid)

endmodule

`default_nettype wire
